// File: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int unsigned CAP_W   = 13;
    localparam int unsigned LEN_W   = 12;
    localparam logic [CAP_W-1:0] CAP_MAX   = 13'd4096;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd160;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TEXT = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    // Results caused by one request: cnt of 0 means none
    typedef struct packed {
        logic [1:0]       cnt;
        status_t          status;
        logic [2:0][7:0]  bytes;
        logic [LEN_W-1:0] len_first;
    } res_t;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

// File: hdl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape state machine: updates decode state per request and forms results.
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [7:0]       in_byte,
    input  logic             start_req,
    input  logic [CAP_W-1:0] capacity,
    output res_t             res
);

    mode_t            mode_reg, mode_next, mode_eff;
    logic [1:0]       hex_reg, hex_next, hex_eff;
    logic [15:0]      cp_reg, cp_next, cp_eff, cp_shift;
    logic [LEN_W-1:0] cnt_reg, cnt_next, cnt_eff;

    logic [4:0]       hv;
    logic [1:0]       want_n;
    logic [2:0][7:0]  want_b;
    logic             fin;
    status_t          fin_st;
    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W-1:0] sum;

    assign mode_eff = start_req ? MODE_TEXT : mode_reg;
    assign hex_eff  = start_req ? 2'd0 : hex_reg;
    assign cp_eff   = start_req ? 16'd0 : cp_reg;
    assign cnt_eff  = start_req ? '0 : cnt_reg;
    assign cap_eff  = (capacity > CAP_MAX) ? CAP_MAX : capacity;
    assign hv       = hex_value(in_byte);
    assign cp_shift = {cp_eff[11:0], hv[3:0]};
    assign sum      = {1'b0, cnt_eff} + CAP_W'(want_n);

    always_comb
    begin
        mode_next = mode_eff;
        hex_next  = hex_eff;
        cp_next   = cp_eff;
        cnt_next  = cnt_eff;
        want_n    = 2'd0;
        want_b    = '0;
        fin       = 1'b0;
        fin_st    = ST_ERR;
        res       = '0;
        unique case (mode_eff)
            MODE_TEXT:
            begin
                if (in_byte == CH_NUL)
                    fin = 1'b1;
                else if (in_byte == CH_QUOTE)
                begin
                    fin    = 1'b1;
                    fin_st = ST_DONE;
                end
                else if (in_byte == CH_BSL)
                    mode_next = MODE_ESC;
                else
                begin
                    want_n    = 2'd1;
                    want_b[0] = in_byte;
                end
            end
            MODE_ESC:
            begin
                if (in_byte == CH_NUL)
                    fin = 1'b1;
                else if (in_byte == CH_U)
                begin
                    mode_next = MODE_HEX;
                    hex_next  = 2'd0;
                    cp_next   = 16'd0;
                end
                else
                begin
                    mode_next = MODE_TEXT;
                    want_n    = 2'd1;
                    case (in_byte)
                        CH_N:    want_b[0] = 8'h0a;
                        CH_R:    want_b[0] = 8'h0d;
                        CH_T:    want_b[0] = 8'h09;
                        CH_B:    want_b[0] = 8'h08;
                        CH_F:    want_b[0] = 8'h0c;
                        default: want_b[0] = in_byte;
                    endcase
                end
            end
            MODE_HEX:
            begin
                if (!hv[4])
                    fin = 1'b1;
                else
                begin
                    cp_next = cp_shift;
                    if (hex_eff != 2'd3)
                        hex_next = hex_eff + 2'd1;
                    else
                    begin
                        hex_next  = 2'd0;
                        mode_next = MODE_TEXT;
                        if (cp_shift <= 16'h007f)
                        begin
                            want_n    = 2'd1;
                            want_b[0] = cp_shift[7:0];
                        end
                        else if (cp_shift <= 16'h07ff)
                        begin
                            want_n    = 2'd2;
                            want_b[0] = 8'hc0 | {3'b000, cp_shift[10:6]};
                            want_b[1] = 8'h80 | {2'b00, cp_shift[5:0]};
                        end
                        else
                        begin
                            want_n    = 2'd3;
                            want_b[0] = 8'he0 | {4'h0, cp_shift[15:12]};
                            want_b[1] = 8'h80 | {2'b00, cp_shift[11:6]};
                            want_b[2] = 8'h80 | {2'b00, cp_shift[5:0]};
                        end
                    end
                end
            end
            default: ;  // idle: byte ignored
        endcase

        // Whole sequence must fit below capacity, else error
        if (want_n != 2'd0)
        begin
            if (sum >= cap_eff)
                fin = 1'b1;
            else
            begin
                cnt_next      = sum[LEN_W-1:0];
                res.cnt       = want_n;
                res.status    = ST_DATA;
                res.bytes     = want_b;
                res.len_first = cnt_eff + LEN_W'(1);
            end
        end

        if (fin)
        begin
            mode_next     = MODE_IDLE;
            hex_next      = 2'd0;
            cp_next       = 16'd0;
            cnt_next      = cnt_eff;
            res.cnt       = 2'd1;
            res.status    = fin_st;
            res.bytes     = '0;
            res.len_first = cnt_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            hex_reg  <= 2'd0;
            cp_reg   <= 16'd0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            cp_reg   <= cp_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: hdl/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register: up to three results, handed out one a cycle on out_ready.
// ----------------------------------------------------------------------------
module jsu_outbuf
    import jsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  res_t             res,
    output logic             load_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       status,
    output logic [LEN_W-1:0] decoded_length,
    output logic             last
);

    logic [1:0]       rem_reg, rem_next;
    logic [1:0]       idx_reg, idx_next;
    logic [2:0][7:0]  bytes_reg;
    status_t          status_reg;
    logic [LEN_W-1:0] len_reg;
    logic             take;

    assign out_valid = (rem_reg != 2'd0);
    assign take      = out_valid && out_ready;
    // Free now, or the final pending result leaves this cycle
    assign load_ok   = (rem_reg == 2'd0) || (rem_reg == 2'd1 && out_ready);

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = res.cnt;
            idx_next = 2'd0;
        end
        else if (take)
        begin
            rem_next = rem_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg  <= res.bytes;
            status_reg <= res.status;
            len_reg    <= res.len_first;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd1:    out_byte = bytes_reg[1];
            2'd2:    out_byte = bytes_reg[2];
            default: out_byte = bytes_reg[0];
        endcase
    end

    assign status         = status_reg;
    assign decoded_length = len_reg + LEN_W'(idx_reg);
    assign last           = (rem_reg == 2'd1);

endmodule

// File: hdl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes a JSON string body byte by byte into UTF-8 with length checking.
// ----------------------------------------------------------------------------
// Timing: the first result of a request appears in the cycle after the request is taken.
// Throughput: one request per cycle while out_ready is high; a request giving
//   n results holds the input while the single result register drains one per ready cycle.
// Reset (rst_n, async, active low): decoder idle, counts cleared, no results
//   pending, cap_reg back to 160.
// ----------------------------------------------------------------------------
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    // request channel
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             start_req,
    // result channel
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       status,
    output logic [LEN_W-1:0] decoded_length,
    output logic             last
);

    logic [CAP_W-1:0] cap_reg;
    logic             load;
    res_t             res;

    // Capacity register; values above 4096 are clamped in the decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_wr_en)
            cap_reg <= cfg_wr_data;
    end

    // A request is taken whenever the result register can be refilled
    assign load = in_valid && in_ready;

    // Escape decoding and length accounting; results are formed combinationally
    jsu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .in_byte   (in_byte),
        .start_req (start_req),
        .capacity  (cap_reg),
        .res       (res)
    );

    // Result register, up to three bytes per request
    jsu_outbuf u_outbuf (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .res            (res),
        .load_ok        (in_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .status         (status),
        .decoded_length (decoded_length),
        .last           (last)
    );

    // Nothing pending means requests are always welcome
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with no results pending");

    // Refill while busy only as the final result leaves
    a_refill_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && out_valid) |-> (last && out_ready))
        else $error("result register refilled before drained");

    // Success and error results are always the only result of their request
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DATA) |-> last)
        else $error("status result not marked last");

    // A data byte always carries a non-zero length
    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_DATA) |-> (decoded_length != '0))
        else $error("data byte with zero length");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for json_string_unescape. A short directed string set
// is followed by random string bodies over several buffer capacities. Both
// handshakes stall at random and the receiver holds off once for a long time.
// A scoreboard class runs its own decoder and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top
    import jsu_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;   // far above the slowest honest run
    localparam int LONG_HOLD   = 300;      // receiver hold-off, in cycles
    localparam int SETTLE      = 4;        // idle cycles before a config write

    // One result as seen on the output channel
    typedef struct packed {
        logic [7:0]       data;
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
        logic             last;
    } result_t;

    // One request on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } request_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the decoder state and holds the decoded results
    // that are still to come out of the block, oldest first.
    // ------------------------------------------------------------------------
    class unescape_scoreboard;
        logic [CAP_W-1:0] capacity;
        mode_t            mode;
        logic [1:0]       digits;
        logic [15:0]      code;
        logic [LEN_W-1:0] count;
        result_t          decoded[$];
        int               mismatches;

        function new();
            capacity   = CAP_RESET;
            mode       = MODE_IDLE;
            digits     = 2'd0;
            code       = 16'd0;
            count      = '0;
            mismatches = 0;
        endfunction

        function void push(logic [7:0] b, status_t st, logic [LEN_W-1:0] len, logic lst);
            decoded.push_back('{data: b, status: st, length: len, last: lst});
        endfunction

        // Success or error: one status result, then back to idle
        function void close_string(status_t st);
            push(8'h00, st, count, 1'b1);
            mode   = MODE_IDLE;
            digits = 2'd0;
            code   = 16'd0;
        endfunction

        // Whole sequence or nothing: a sequence that would reach the
        // capacity turns into an error instead
        function void emit(logic [2:0][7:0] seq, int n);
            int cap_eff;
            cap_eff = (capacity > CAP_MAX) ? int'(CAP_MAX) : int'(capacity);
            if (int'(count) + n >= cap_eff)
                close_string(ST_ERR);
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    count = count + 1'b1;
                    push(seq[i], ST_DATA, count, (i == n - 1));
                end
            end
        endfunction

        function int nibble_of(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39)
                return int'(c) - 'h30;
            if (c >= 8'h61 && c <= 8'h66)
                return int'(c) - 'h61 + 10;
            if (c >= 8'h41 && c <= 8'h46)
                return int'(c) - 'h41 + 10;
            return -1;
        endfunction

        // Accepted request: work out every result it causes
        function void decode_request(request_t r);
            logic [7:0]      c;
            logic [2:0][7:0] seq;
            int              d;
            c   = r.data;
            seq = '0;
            if (r.start)
            begin
                count  = '0;
                mode   = MODE_TEXT;
                digits = 2'd0;
                code   = 16'd0;
            end
            case (mode)
                MODE_TEXT:
                begin
                    if (c == CH_NUL)
                        close_string(ST_ERR);
                    else if (c == CH_QUOTE)
                        close_string(ST_DONE);
                    else if (c == CH_BSL)
                        mode = MODE_ESC;
                    else
                    begin
                        seq[0] = c;
                        emit(seq, 1);
                    end
                end
                MODE_ESC:
                begin
                    if (c == CH_NUL)
                        close_string(ST_ERR);
                    else if (c == CH_U)
                    begin
                        mode   = MODE_HEX;
                        digits = 2'd0;
                        code   = 16'd0;
                    end
                    else
                    begin
                        mode = MODE_TEXT;
                        case (c)
                            CH_N:    seq[0] = 8'h0a;
                            CH_R:    seq[0] = 8'h0d;
                            CH_T:    seq[0] = 8'h09;
                            CH_B:    seq[0] = 8'h08;
                            CH_F:    seq[0] = 8'h0c;
                            default: seq[0] = c;
                        endcase
                        emit(seq, 1);
                    end
                end
                MODE_HEX:
                begin
                    d = nibble_of(c);
                    if (d < 0)
                        close_string(ST_ERR);
                    else
                    begin
                        code = {code[11:0], 4'(d)};
                        if (digits < 2'd3)
                            digits = digits + 1'b1;
                        else
                        begin
                            digits = 2'd0;
                            mode   = MODE_TEXT;
                            if (code <= 16'h007f)
                            begin
                                seq[0] = code[7:0];
                                emit(seq, 1);
                            end
                            else if (code <= 16'h07ff)
                            begin
                                seq[0] = 8'hc0 | 8'(code >> 6);
                                seq[1] = 8'h80 | {2'b00, code[5:0]};
                                emit(seq, 2);
                            end
                            else
                            begin
                                seq[0] = 8'he0 | 8'(code >> 12);
                                seq[1] = 8'h80 | {2'b00, code[11:6]};
                                seq[2] = 8'h80 | {2'b00, code[5:0]};
                                emit(seq, 3);
                            end
                        end
                    end
                end
                default: ;  // idle without start: byte ignored
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (decoded.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %h status %0d length %0d last %0b",
                             got.data, got.status, got.length, got.last);
                return;
            end
            want = decoded.pop_front();
            if (got.data !== want.data || got.status !== want.status ||
                got.length !== want.length || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%0d/%0d/%0b got %h/%0d/%0d/%0b",
                             want.data, want.status, want.length, want.last,
                             got.data, got.status, got.length, got.last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its signals
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       in_byte;
    logic             start_req;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       out_byte;
    logic [1:0]       status;
    logic [LEN_W-1:0] decoded_length;
    logic             last;

    json_string_unescape dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .start_req      (start_req),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .status         (status),
        .decoded_length (decoded_length),
        .last           (last)
    );

    always #5 clk = ~clk;

    unescape_scoreboard sb = new();

    request_t stimulus[$];
    logic     open_next;          // next byte added carries start_req
    int       tx_gap_pct;         // chance of a sender gap before a request
    int       rx_stall_pct;       // chance per cycle of a receiver stall burst
    bit       long_hold_req = 1'b0;
    int       cycle_count = 0;

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: sampled at the edge, so all values are pre-edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{data: out_byte, status: status,
                              length: decoded_length, last: last});
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request from
    // the main sequence; this process counts the hold-off itself.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        stimulus.push_back('{data: b, start: open_next});
        open_next = 1'b0;
    endfunction

    // Upper or lower case picked at random for a to f
    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void add_unicode(logic [15:0] cp);
        add_byte(CH_BSL);
        add_byte(CH_U);
        add_byte(hex_char(cp[15:12]));
        add_byte(hex_char(cp[11:8]));
        add_byte(hex_char(cp[7:4]));
        add_byte(hex_char(cp[3:0]));
    endfunction

    // Code points spread over the 1, 2 and 3 byte ranges and their borders
    function automatic logic [15:0] random_code();
        logic [15:0] border[7];
        border = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff, 16'hd800};
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 'h7f));
            1: return 16'($urandom_range('h80, 'h7ff));
            2, 3: return 16'($urandom_range('h800, 'hffff));
            default: return border[$urandom_range(0, 6)];
        endcase
    endfunction

    // Non-hex byte, often one just outside a digit range
    function automatic logic [7:0] bad_hex();
        logic [7:0] near[7];
        logic [7:0] c;
        near = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67, CH_NUL};
        if ($urandom_range(0, 1))
            return near[$urandom_range(0, 6)];
        do
            c = 8'($urandom_range(0, 255));
        while (sb.nibble_of(c) >= 0);
        return c;
    endfunction

    function automatic void add_escape();
        logic [7:0] pick[8];
        logic [7:0] c;
        pick = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_QUOTE, CH_BSL, 8'h2f};
        add_byte(CH_BSL);
        if ($urandom_range(0, 3) == 0)
        begin
            // any other escaped byte passes through as itself
            do
                c = 8'($urandom_range(1, 255));
            while (c == CH_U);
            add_byte(c);
        end
        else
            add_byte(pick[$urandom_range(0, 7)]);
    endfunction

    // One string body: random content, then a closing quote, an error of
    // some kind, or no end at all so the next start cuts it off
    function automatic void add_string();
        int         body_len;
        int         sel;
        logic [7:0] c;
        open_next = 1'b1;
        body_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 45) : $urandom_range(0, 8);
        for (int i = 0; i < body_len; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == CH_QUOTE || c == CH_BSL);
                add_byte(c);
            end
            else if (sel < 8)
                add_escape();
            else
                add_unicode(random_code());
        end
        sel = $urandom_range(0, 19);
        if (sel < 13)
            add_byte(CH_QUOTE);
        else if (sel == 13)
            add_byte(CH_NUL);
        else if (sel == 14)
        begin
            add_byte(CH_BSL);
            add_byte(CH_NUL);
        end
        else if (sel < 18)
        begin
            // broken \u: a few good digits then a bad one
            add_byte(CH_BSL);
            add_byte(CH_U);
            repeat ($urandom_range(0, 3))
                add_byte(hex_char(4'($urandom_range(0, 15))));
            add_byte(bad_hex());
        end
        // otherwise left open
    endfunction

    task automatic build_directed();
        open_next = 1'b1;
        add_byte(8'hff);                 // top byte value as plain text
        add_byte(CH_BSL);
        add_byte(CH_N);
        add_unicode(16'h07ff);           // largest two byte sequence
        add_byte(CH_BSL);                // \uFfFf, mixed case, three bytes
        add_byte(CH_U);
        add_byte(8'h46);
        add_byte(8'h66);
        add_byte(8'h46);
        add_byte(8'h66);
        add_byte(CH_QUOTE);
        add_byte(8'h41);                 // idle byte, ignored
        open_next = 1'b1;                // NUL straight after a backslash
        add_byte(CH_BSL);
        add_byte(CH_NUL);
        open_next = 1'b1;                // non-hex byte inside \u
        add_byte(CH_BSL);
        add_byte(CH_U);
        add_byte(8'h67);
        open_next = 1'b1;                // NUL in plain text
        add_byte(CH_NUL);
        open_next = 1'b1;                // empty string
        add_byte(CH_QUOTE);
    endtask

    // ------------------------------------------------------------------------
    // Drivers: each task starts and ends just after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_request(request_t r);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= r.data;
        start_req <= r.start;
        do
            @(posedge clk);
        while (!in_ready);
        sb.decode_request(r);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.capacity = v;
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic wait_drained();
        while (sb.decoded.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_stimulus();
        foreach (stimulus[i])
            send_request(stimulus[i]);
        in_valid <= 1'b0;
        wait_drained();
    endtask

    // Random phase of exactly n requests at one capacity; the last string
    // may be cut short, which leaves it open for the next start
    task automatic run_phase(logic [CAP_W-1:0] cap, int n, int tx_pct, int rx_pct, bit hold);
        write_capacity(cap);
        stimulus.delete();
        while (stimulus.size() < n)
        begin
            add_string();
            if ($urandom_range(0, 7) == 0)
            begin
                open_next = 1'b0;
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom_range(0, 255)));
            end
        end
        while (stimulus.size() > n)
            void'(stimulus.pop_back());
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold)
            long_hold_req = 1'b1;
        run_stimulus();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        in_byte      = '0;
        start_req    = 1'b0;
        open_next    = 1'b0;
        tx_gap_pct   = 20;
        rx_stall_pct = 10;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed set runs at the reset capacity
        build_directed();
        run_stimulus();

        // capacities 1 and 0 overflow on the first emit
        run_phase(13'd1, 25, 20, 10, 1'b0);
        run_phase(13'd0, 20, 20, 10, 1'b0);
        run_phase(13'd2, 20, 0, 0, 1'b0);
        run_phase(13'd3, 20, 30, 15, 1'b0);
        // top of the register acts as 4096; sender keeps pushing while held
        run_phase(13'h1fff, 40, 0, 5, 1'b1);
        run_phase(13'($urandom_range(4, 40)), 35, 25, 15, 1'b0);
        run_phase(CAP_MAX, 30, 15, 10, 1'b0);
        run_phase(13'($urandom_range(4, 40)), 20, 20, 10, 1'b0);
        // closing stretch without idling on either side
        run_phase(CAP_RESET, 25, 0, 0, 1'b0);

        repeat (5) @(posedge clk);
        if (sb.decoded.size() != 0)
            $display("%0d expected results never arrived", sb.decoded.size());
        if (sb.mismatches == 0 && sb.decoded.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
